### design/pst_pkg.sv
package pst_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_ALLOW  = 2'd1;
    localparam logic [1:0] OP_DENY   = 2'd2;
    // spare code: accepted with an all-clear result and no store change
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_WINDOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WATCHED_PORT_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WATCHED_PORT_B = 3'd4;

    localparam logic [15:0] RST_SCAN_THRESHOLD = 16'd10;
    localparam logic [15:0] RST_AGE_WINDOW     = 16'd10;
    localparam logic [15:0] RST_LARGE_LENGTH   = 16'd1500;
    localparam logic [15:0] RST_WATCHED_PORT_A = 16'd22;
    localparam logic [15:0] RST_WATCHED_PORT_B = 16'd23;
    localparam logic [15:0] ATTEMPT_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] source_address;
        logic [15:0] packet_length;
        logic [15:0] destination_port;
        logic [31:0] now_seconds;
    } item_t;

    typedef struct packed {
        logic large_packet;
        logic watched_port;
        logic whitelisted;
        logic scan_alert;
        logic deny_alert;
        logic store_full;
    } res_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

### design/pst_in_if.sv
interface pst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] source_address;
    logic [15:0] packet_length;
    logic [15:0] destination_port;
    logic [31:0] now_seconds;

    modport source (output valid, operation, source_address, packet_length,
                    destination_port, now_seconds, input ready);
    modport sink (input valid, operation, source_address, packet_length,
                  destination_port, now_seconds, output ready);
endinterface

### design/pst_out_if.sv
interface pst_out_if;
    logic valid;
    logic ready;
    logic large_packet;
    logic watched_port;
    logic whitelisted;
    logic scan_alert;
    logic deny_alert;
    logic store_full;

    modport source (output valid, large_packet, watched_port, whitelisted, scan_alert,
                    deny_alert, store_full, input ready);
    modport sink (input valid, large_packet, watched_port, whitelisted, scan_alert,
                  deny_alert, store_full, output ready);
endinterface

### design/pst_cfg_if.sv
interface pst_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/port_scan_source_tracker_top.sv
// Port scan source tracker.
// Channels: "in" carries a packet header (operation 0) or a command adding an
// address to the allow list (1) or deny list (2); "out" returns one result item
// per input item; "cfg" writes the five 16-bit registers (index 0..4), always ready.
// A list command is accepted and then finished without a walk. A packet
// walks the tracked table (compacting aged entries in place) while the allow
// and deny lists are searched in parallel; the walk runs until all three
// stores are read to their fill counts. One item is worked on at a time; the
// next item is accepted once the previous result lands in the output register.
// Reset clears the table and list fill counts and loads the register defaults;
// no clearing pass is needed. If the receiver stalls, the result is held and
// the next item runs its walk, then waits for the output register to free.
module port_scan_source_tracker_top #(
    parameter int TABLE_DEPTH = 128,
    parameter int LIST_DEPTH  = 128
)
(
    input logic      clk,
    input logic      rst_n,
    pst_in_if.sink   in,
    pst_out_if.source out,
    pst_cfg_if.sink  cfg
);

    pst_pkg::cmd_t  cmd;
    pst_pkg::stat_t stat;
    pst_pkg::item_t item;
    pst_pkg::res_t  res;

    assign item.operation        = in.operation;
    assign item.source_address   = in.source_address;
    assign item.packet_length    = in.packet_length;
    assign item.destination_port = in.destination_port;
    assign item.now_seconds      = in.now_seconds;

    assign cfg.ready = 1'b1;

    pst_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in.valid),
        .in_operation (in.operation),
        .in_ready     (in.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    pst_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LIST_DEPTH  (LIST_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_ready (out.ready),
        .out_valid (out.valid),
        .res       (res)
    );

    assign out.large_packet = res.large_packet;
    assign out.watched_port = res.watched_port;
    assign out.whitelisted  = res.whitelisted;
    assign out.scan_alert   = res.scan_alert;
    assign out.deny_alert   = res.deny_alert;
    assign out.store_full   = res.store_full;

endmodule

### design/pst_ctrl.sv
module pst_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     in_operation,
    output logic           in_ready,
    input  pst_pkg::stat_t stat,
    output pst_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_operation == pst_pkg::OP_PACKET) ? S_SCAN : S_FIN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/pst_datapath.sv
module pst_datapath #(
    parameter int TABLE_DEPTH = 128,
    parameter int LIST_DEPTH  = 128
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pst_pkg::item_t                item,
    input  pst_pkg::cmd_t                 cmd,
    output pst_pkg::stat_t                stat,
    input  logic                          cfg_valid,
    input  logic [pst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output pst_pkg::res_t                 res
);

    localparam int TW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TCW = $clog2(TABLE_DEPTH + 1);
    localparam int LW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LCW = $clog2(LIST_DEPTH + 1);

    // configuration
    logic [15:0] thr_reg, age_reg, large_reg, port_a_reg, port_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= pst_pkg::RST_SCAN_THRESHOLD;
            age_reg    <= pst_pkg::RST_AGE_WINDOW;
            large_reg  <= pst_pkg::RST_LARGE_LENGTH;
            port_a_reg <= pst_pkg::RST_WATCHED_PORT_A;
            port_b_reg <= pst_pkg::RST_WATCHED_PORT_B;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pst_pkg::REG_SCAN_THRESHOLD: thr_reg    <= cfg_data;
                pst_pkg::REG_AGE_WINDOW:     age_reg    <= cfg_data;
                pst_pkg::REG_LARGE_LENGTH:   large_reg  <= cfg_data;
                pst_pkg::REG_WATCHED_PORT_A: port_a_reg <= cfg_data;
                pst_pkg::REG_WATCHED_PORT_B: port_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pst_pkg::item_t item_reg;

    logic [TCW-1:0] t_used_reg, rd_reg, w_reg;
    logic [LCW-1:0] a_used_reg, d_used_reg, lr_reg;
    logic           t_pend_reg, a_pend_reg, d_pend_reg;
    logic           found_reg, white_reg, deny_reg;
    logic [TW-1:0]  match_reg;
    logic [15:0]    match_att_reg;
    logic           out_valid_reg;
    pst_pkg::res_t  res_reg;
    pst_pkg::res_t  fin_res;
    logic [TCW-1:0] fin_t_used;

    // memories
    logic [31:0] t_addr_mem [TABLE_DEPTH];
    logic [15:0] t_att_mem  [TABLE_DEPTH];
    logic [31:0] t_time_mem [TABLE_DEPTH];
    logic [31:0] a_mem      [LIST_DEPTH];
    logic [31:0] d_mem      [LIST_DEPTH];

    logic [31:0] t_q_addr, t_q_time, a_q, d_q;
    logic [15:0] t_q_att;

    logic        t_more, a_more, d_more, t_re, a_re, d_re;
    logic [31:0] elapsed;
    logic        survive;
    logic        t_we;
    logic [TW-1:0] t_widx;
    logic [31:0] t_waddr, t_wtime;
    logic [15:0] t_watt, att_inc;
    logic        is_pkt, a_room, d_room, t_room;

    assign t_more = rd_reg < t_used_reg;
    assign a_more = lr_reg < a_used_reg;
    assign d_more = lr_reg < d_used_reg;
    assign t_re   = cmd.scan && t_more;
    assign a_re   = cmd.scan && a_more;
    assign d_re   = cmd.scan && d_more;

    assign elapsed = item_reg.now_seconds - t_q_time;
    assign survive = elapsed <= {16'd0, age_reg};
    assign att_inc = (match_att_reg == pst_pkg::ATTEMPT_MAX) ? match_att_reg
                                                             : match_att_reg + 16'd1;
    assign is_pkt  = item_reg.operation == pst_pkg::OP_PACKET;
    assign t_room  = w_reg < TCW'(TABLE_DEPTH);
    assign a_room  = a_used_reg < LCW'(LIST_DEPTH);
    assign d_room  = d_used_reg < LCW'(LIST_DEPTH);

    assign stat.scan_done = !t_more && !a_more && !d_more
                            && !t_pend_reg && !a_pend_reg && !d_pend_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    // table write: compaction during the walk, update or insert at finish
    always_comb
    begin
        t_we    = cmd.scan && t_pend_reg && survive;
        t_widx  = w_reg[TW-1:0];
        t_waddr = t_q_addr;
        t_watt  = t_q_att;
        t_wtime = t_q_time;
        if (cmd.finish && is_pkt && !white_reg)
        begin
            t_waddr = item_reg.source_address;
            t_wtime = item_reg.now_seconds;
            if (found_reg)
            begin
                t_we   = 1'b1;
                t_widx = match_reg;
                t_watt = att_inc;
            end
            else
            begin
                t_we   = t_room;
                t_watt = 16'd1;
            end
        end
    end

    // result and new table count at finish
    always_comb
    begin
        fin_res    = '0;
        fin_t_used = t_used_reg;
        case (item_reg.operation)
            pst_pkg::OP_PACKET:
            begin
                fin_res.large_packet = item_reg.packet_length > large_reg;
                fin_res.watched_port = item_reg.destination_port == port_a_reg
                                       || item_reg.destination_port == port_b_reg;
                fin_t_used = w_reg;
                if (white_reg)
                begin
                    fin_res.whitelisted = 1'b1;
                end
                else if (found_reg)
                begin
                    fin_res.scan_alert = att_inc > thr_reg;
                    fin_res.deny_alert = (att_inc > thr_reg) && deny_reg;
                end
                else if (t_room)
                begin
                    fin_t_used = w_reg + TCW'(1);
                end
                else
                begin
                    fin_res.store_full = 1'b1;
                end
            end
            pst_pkg::OP_ALLOW:
            begin
                fin_res.store_full = !a_room;
            end
            pst_pkg::OP_DENY:
            begin
                fin_res.store_full = !d_room;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (t_re)
        begin
            t_q_addr <= t_addr_mem[rd_reg[TW-1:0]];
            t_q_att  <= t_att_mem[rd_reg[TW-1:0]];
            t_q_time <= t_time_mem[rd_reg[TW-1:0]];
        end
        if (t_we)
        begin
            t_addr_mem[t_widx] <= t_waddr;
            t_att_mem[t_widx]  <= t_watt;
            t_time_mem[t_widx] <= t_wtime;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_re)
        begin
            a_q <= a_mem[lr_reg[LW-1:0]];
        end
        if (cmd.finish && item_reg.operation == pst_pkg::OP_ALLOW && a_room)
        begin
            a_mem[a_used_reg[LW-1:0]] <= item_reg.source_address;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_re)
        begin
            d_q <= d_mem[lr_reg[LW-1:0]];
        end
        if (cmd.finish && item_reg.operation == pst_pkg::OP_DENY && d_room)
        begin
            d_mem[d_used_reg[LW-1:0]] <= item_reg.source_address;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.scan && t_pend_reg && survive && !found_reg
            && t_q_addr == item_reg.source_address)
        begin
            match_reg     <= w_reg[TW-1:0];
            match_att_reg <= t_q_att;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_used_reg    <= '0;
            a_used_reg    <= '0;
            d_used_reg    <= '0;
            rd_reg        <= '0;
            w_reg         <= '0;
            lr_reg        <= '0;
            t_pend_reg    <= 1'b0;
            a_pend_reg    <= 1'b0;
            d_pend_reg    <= 1'b0;
            found_reg     <= 1'b0;
            white_reg     <= 1'b0;
            deny_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_reg     <= '0;
                w_reg      <= '0;
                lr_reg     <= '0;
                t_pend_reg <= 1'b0;
                a_pend_reg <= 1'b0;
                d_pend_reg <= 1'b0;
                found_reg  <= 1'b0;
                white_reg  <= 1'b0;
                deny_reg   <= 1'b0;
            end
            if (cmd.scan)
            begin
                t_pend_reg <= t_re;
                a_pend_reg <= a_re;
                d_pend_reg <= d_re;
                if (t_re)
                begin
                    rd_reg <= rd_reg + TCW'(1);
                end
                if (a_re || d_re)
                begin
                    lr_reg <= lr_reg + LCW'(1);
                end
                if (t_pend_reg && survive)
                begin
                    w_reg <= w_reg + TCW'(1);
                    if (t_q_addr == item_reg.source_address)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                if (a_pend_reg && a_q == item_reg.source_address)
                begin
                    white_reg <= 1'b1;
                end
                if (d_pend_reg && d_q == item_reg.source_address)
                begin
                    deny_reg <= 1'b1;
                end
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                res_reg       <= fin_res;
                t_used_reg    <= fin_t_used;
                if (item_reg.operation == pst_pkg::OP_ALLOW && a_room)
                begin
                    a_used_reg <= a_used_reg + LCW'(1);
                end
                if (item_reg.operation == pst_pkg::OP_DENY && d_room)
                begin
                    d_used_reg <= d_used_reg + LCW'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        t_used_reg <= TCW'(TABLE_DEPTH) && a_used_reg <= LCW'(LIST_DEPTH)
        && d_used_reg <= LCW'(LIST_DEPTH))
        else $error("store count beyond depth");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan && t_pend_reg |-> w_reg < rd_reg)
        else $error("compaction write overtakes read");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free && (!is_pkt || stat.scan_done))
        else $error("finish while output busy or walk pending");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(res_reg))
        else $error("pending result lost");

endmodule
